FILE: rtl/ptc_pkg.sv
// ---------------------------------------------------------------------------
// ptc_pkg
// Types and constants shared by the partition table checker modules.
// ---------------------------------------------------------------------------
package ptc_pkg;

  localparam logic [7:0] CYL_HIGH_BITS = 8'hc0;
  localparam logic [7:0] SEC_BITS      = 8'h3f;
  localparam logic [7:0] ACTIVE_MARK   = 8'd128;
  localparam logic [2:0] ACTIVE_MAX    = 3'd7;

  localparam logic CFG_HEADS   = 1'b0;
  localparam logic CFG_SECTORS = 1'b1;

  typedef struct packed {
    logic [7:0]  boot_flag;
    logic [7:0]  first_head;
    logic [7:0]  start_sector_field;
    logic [7:0]  start_cylinder_low;
    logic [7:0]  end_head;
    logic [7:0]  end_sector_field;
    logic [7:0]  end_cylinder_low;
    logic [31:0] base_sector;
    logic [31:0] sector_count;
    logic        last_entry;
  } ptc_in_t;

  typedef struct packed {
    logic       base_mismatch;
    logic       size_mismatch;
    logic       overlap;
    logic       end_overflow;
    logic       table_done;
    logic       table_empty;
    logic       geometry_mismatch;
    logic [8:0] suggested_heads;
    logic [5:0] suggested_sectors;
    logic       too_many_active;
    logic       table_ok;
  } ptc_out_t;

  // item after front-end classification
  typedef struct packed {
    logic [7:0]  s_hd;
    logic [7:0]  s_sc;
    logic [7:0]  s_cy;
    logic [7:0]  e_hd;
    logic [7:0]  e_sc;
    logic [7:0]  e_cy;
    logic [31:0] base;
    logic [31:0] end_lba;
    logic        zero_end;
    logic        nonempty;
    logic        active;
    logic        last;
  } ptc_job_t;

endpackage

FILE: rtl/ptc_front.sv
// ---------------------------------------------------------------------------
// ptc_front
// Accepts entries, computes end sector and classifies them into jobs.
// ---------------------------------------------------------------------------
module ptc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  ptc_pkg::ptc_in_t  in_data,
  output logic              job_valid,
  input  logic              job_take,
  output ptc_pkg::ptc_job_t job
);
  import ptc_pkg::*;

  localparam int Depth = 2;

  ptc_job_t   q_r [Depth];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  ptc_job_t   j;

  always_comb begin
    j.s_hd     = in_data.first_head;
    j.s_sc     = in_data.start_sector_field;
    j.s_cy     = in_data.start_cylinder_low;
    j.e_hd     = in_data.end_head;
    j.e_sc     = in_data.end_sector_field;
    j.e_cy     = in_data.end_cylinder_low;
    j.base     = in_data.base_sector;
    j.end_lba  = in_data.base_sector + in_data.sector_count - 32'd1;
    j.zero_end = (in_data.base_sector == '0) && (in_data.sector_count == '0);
    j.nonempty = in_data.sector_count != '0;
    j.active   = in_data.boot_flag == ACTIVE_MARK;
    j.last     = in_data.last_entry;
  end

  assign in_full   = cnt_r == 2'(Depth);
  assign job_valid = cnt_r != 2'd0;
  assign job       = q_r[rp_r];

  wire push_ok = in_push && !in_full;
  wire pop_ok  = job_take && job_valid;

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wp_r] <= j;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push_ok) wp_r <= ~wp_r;
      if (pop_ok)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push_ok) - 2'(pop_ok);
    end
  end
endmodule

FILE: rtl/ptc_divider.sv
// ---------------------------------------------------------------------------
// ptc_divider
// Radix-2 restoring divider, 32-bit dividend by 15-bit divisor.
// ---------------------------------------------------------------------------
module ptc_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [14:0] divisor,
  output logic        busy,
  output logic [31:0] quotient,
  output logic [14:0] remainder
);
  logic [31:0] q_r;
  logic [15:0] rem_r;
  logic [14:0] d_r;
  logic [5:0]  cnt_r;
  logic [15:0] trial;
  logic [15:0] shifted;

  assign shifted   = {rem_r[14:0], q_r[31]};
  assign trial     = shifted - {1'b0, d_r};
  assign busy      = cnt_r != 6'd0;
  assign quotient  = q_r;
  assign remainder = rem_r[14:0];

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend; rem_r <= '0; d_r <= divisor;
    end else if (busy) begin
      if (!trial[15]) begin
        rem_r <= trial; q_r <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= shifted; q_r <= {q_r[30:0], 1'b0};
      end
    end
    if (!rst_n) cnt_r <= 6'd0;
    else if (start) cnt_r <= 6'd32;
    else if (busy) cnt_r <= cnt_r - 6'd1;
  end
endmodule

FILE: rtl/ptc_back.sv
// ---------------------------------------------------------------------------
// ptc_back
// Converts base and end sectors to packed CHS, checks, keeps table state.
// ---------------------------------------------------------------------------
module ptc_back #(
  parameter int TABLE_ENTRIES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [8:0]        heads,
  input  logic [5:0]        spt,
  input  logic              job_valid,
  output logic              job_take,
  input  ptc_pkg::ptc_job_t job,
  output logic              res_valid,
  input  logic              res_take,
  output ptc_pkg::ptc_out_t res
);
  import ptc_pkg::*;

  localparam int CntW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIVC = 7'b0000010,
    S_DIVH = 7'b0000100,
    S_PASS = 7'b0001000,
    S_EVAL = 7'b0010000,
    S_OUT  = 7'b0100000,
    S_MUL  = 7'b1000000
  } st_t;

  st_t         st_r, st_nxt;
  ptc_job_t    jb_r;
  logic        pass_r;
  logic [14:0] pc_r;
  logic [5:0]  ns;
  logic [8:0]  nh;
  logic [31:0] cyl_r;
  logic [7:0]  hd_s_r, sc_s_r, cy_s_r;
  logic [7:0]  hd_e_r, sc_e_r, cy_e_r;
  logic        div_start;
  logic [31:0] div_a, div_q;
  logic [14:0] div_d, div_r;
  logic        div_busy;
  logic [2:0]  act_r;
  logic [31:0] prev_r;
  logic [7:0]  mh_r;
  logic [5:0]  ms_r;
  logic        any_r, err_r;
  logic [CntW-1:0] ent_r;
  ptc_out_t    res_r;
  logic        rv_r;

  assign nh = (heads == '0) ? 9'd1 : heads;
  assign ns = (spt == '0) ? 6'd1 : spt;

  always_ff @(posedge clk) pc_r <= 15'(nh * ns);

  ptc_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
    .divisor(div_d), .busy(div_busy), .quotient(div_q), .remainder(div_r)
  );

  wire [31:0] lba = pass_r ? jb_r.end_lba : jb_r.base;

  // sequencing: MUL -> start div lba/pc -> DIVC wait -> start div rem/ns -> DIVH wait
  logic       go_r;
  logic       phase_r;
  assign div_a = phase_r ? 32'(div_r) : lba;
  assign div_d = phase_r ? 15'(ns) : pc_r;

  assign job_take  = (st_r == S_IDLE) && job_valid;
  assign res_valid = rv_r;
  assign res       = res_r;

  logic [7:0] hd_c, sc_c, cy_c;
  always_comb begin
    hd_c = div_q[7:0];
    sc_c = 8'(div_r) + 8'd1 + (cyl_r[9:2] & CYL_HIGH_BITS);
    cy_c = cyl_r[7:0];
  end

  logic [2:0] act_n;
  logic [7:0] mh_n;
  logic [5:0] ms_n;
  logic       bb, sb, ov, wr, dn, er_n, any_n, many;
  logic [CntW-1:0] ent_n;
  logic [8:0] sug_h;
  always_comb begin
    act_n = (jb_r.active && act_r < ACTIVE_MAX) ? act_r + 3'd1 : act_r;
    bb = (hd_s_r != jb_r.s_hd) || (sc_s_r != jb_r.s_sc) || (cy_s_r != jb_r.s_cy);
    sb = jb_r.zero_end ?
         ((jb_r.e_hd != '0) || (jb_r.e_sc != '0) || (jb_r.e_cy != '0)) :
         ((hd_e_r != jb_r.e_hd) || (sc_e_r != jb_r.e_sc) || (cy_e_r != jb_r.e_cy));
    ov = jb_r.nonempty && (jb_r.base <= prev_r);
    wr = jb_r.nonempty && (jb_r.end_lba < jb_r.base);
    mh_n = mh_r; ms_n = ms_r;
    if (jb_r.nonempty) begin
      if (mh_n < jb_r.s_hd) mh_n = jb_r.s_hd;
      if (mh_n < jb_r.e_hd) mh_n = jb_r.e_hd;
      if (ms_n < jb_r.s_sc[5:0]) ms_n = jb_r.s_sc[5:0];
      if (ms_n < jb_r.e_sc[5:0]) ms_n = jb_r.e_sc[5:0];
    end
    any_n = any_r || jb_r.nonempty;
    er_n  = err_r || bb || sb || ov || wr;
    ent_n = ent_r + CntW'(1);
    dn    = jb_r.last || (ent_n >= CntW'(TABLE_ENTRIES));
    sug_h = {1'b0, mh_n} + 9'd1;
    many  = act_n > 3'd1;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (job_valid) st_nxt = S_MUL;
      S_MUL:  st_nxt = S_DIVC;
      S_DIVC: if (go_r && !div_busy) st_nxt = S_DIVH;
      S_DIVH: if (go_r && !div_busy) st_nxt = S_PASS;
      S_PASS: st_nxt = pass_r ? S_EVAL : S_DIVC;
      S_EVAL: if (!rv_r || res_take) st_nxt = S_OUT;
      S_OUT:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  logic start_w;
  assign start_w = ((st_r == S_DIVC) || (st_r == S_DIVH)) && !go_r;

  // divider is started in the cycle each wait state is entered
  assign div_start = start_w;

  always_ff @(posedge clk) begin
    if (job_take) jb_r <= job;
    if (st_r == S_DIVC && go_r && !div_busy) cyl_r <= div_q;
    if (st_r == S_DIVH && go_r && !div_busy) begin
      if (pass_r) begin
        hd_e_r <= hd_c; sc_e_r <= sc_c; cy_e_r <= cy_c;
      end else begin
        hd_s_r <= hd_c; sc_s_r <= sc_c; cy_s_r <= cy_c;
      end
    end
    if (st_r == S_EVAL && (!rv_r || res_take)) begin
      res_r.base_mismatch     <= bb;
      res_r.size_mismatch     <= sb;
      res_r.overlap           <= ov;
      res_r.end_overflow      <= wr;
      res_r.table_done        <= dn;
      res_r.table_empty       <= dn && !any_n;
      res_r.geometry_mismatch <= dn && any_n && (sug_h != heads || ms_n != spt);
      res_r.suggested_heads   <= dn ? sug_h : 9'd0;
      res_r.suggested_sectors <= dn ? ms_n : 6'd0;
      res_r.too_many_active   <= dn && many;
      res_r.table_ok          <= dn && !(er_n || many);
    end
    if (!rst_n) begin
      st_r <= S_IDLE; pass_r <= 1'b0; go_r <= 1'b0; phase_r <= 1'b0; rv_r <= 1'b0;
      act_r <= '0; prev_r <= '0; mh_r <= '0; ms_r <= '0;
      any_r <= 1'b0; err_r <= 1'b0; ent_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (res_take && rv_r) rv_r <= 1'b0;
      if (start_w) go_r <= 1'b1;
      else if (go_r && !div_busy) go_r <= 1'b0;
      if (st_r == S_DIVC && go_r && !div_busy) phase_r <= 1'b1;
      if (st_r == S_DIVH && go_r && !div_busy) phase_r <= 1'b0;
      if (job_take) pass_r <= 1'b0;
      else if (st_r == S_PASS) pass_r <= 1'b1;
      if (st_r == S_EVAL && (!rv_r || res_take)) begin
        rv_r <= 1'b1;
        if (dn) begin
          act_r <= '0; prev_r <= '0; mh_r <= '0; ms_r <= '0;
          any_r <= 1'b0; err_r <= 1'b0; ent_r <= '0;
        end else begin
          act_r <= act_n; mh_r <= mh_n; ms_r <= ms_n;
          any_r <= any_n; err_r <= er_n; ent_r <= ent_n;
          if (jb_r.nonempty) prev_r <= jb_r.end_lba;
        end
      end
    end
  end
endmodule

FILE: rtl/partition_table_checker_top.sv
// Each input transfer goes through four 32-step serial divisions (cylinder
// and head for base and end sector) plus take, setup, two pass steps,
// evaluate and output before its result appears.
// Entries are handled one at a time, paced by the shared divider, and an
// unread result holds the checker in its evaluate step.
// Reset (rst_n, synchronous): heads 4, sectors 17, table state cleared.
// ---------------------------------------------------------------------------
// partition_table_checker_top
// MBR partition table CHS consistency checker.
// ---------------------------------------------------------------------------
module partition_table_checker_top #(
  parameter int TABLE_ENTRIES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  ptc_pkg::ptc_in_t  in_data,
  output logic              out_empty,
  input  logic              out_pop,
  output ptc_pkg::ptc_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [8:0]        cfg_data
);
  import ptc_pkg::*;

  logic [8:0] heads_r;
  logic [5:0] spt_r;
  logic       job_valid, job_take, res_valid;
  ptc_job_t   job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heads_r <= 9'd4; spt_r <= 6'd17;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEADS:   heads_r <= cfg_data;
        CFG_SECTORS: spt_r   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  ptc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_data(in_data), .job_valid(job_valid), .job_take(job_take), .job(job)
  );

  ptc_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk(clk), .rst_n(rst_n), .heads(heads_r), .spt(spt_r),
    .job_valid(job_valid), .job_take(job_take), .job(job),
    .res_valid(res_valid), .res_take(out_pop), .res(out_data)
  );

  assign out_empty = !res_valid;

  a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_data.table_done |-> out_data.suggested_heads == '0)
    else $error("summary set before table end");
  a_ok_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.table_ok |-> !out_data.overlap && !out_data.too_many_active)
    else $error("table_ok with error");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty)
    else $error("result dropped");
endmodule

FILE: sim/tb_partition_table_checker_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_partition_table_checker_top
// Drives partition table entries through the checker under several disk
// geometries, predicts each verdict in a local model and compares every
// transfer as a whole, with random idling and one long output hold-off.
// ---------------------------------------------------------------------------
module tb_partition_table_checker_top;
  import ptc_pkg::*;

  localparam int NENTRIES = 4;
  localparam int WATCHDOG = 20000;

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  ptc_in_t in_data;
  logic out_empty;
  logic out_pop;
  ptc_out_t out_data;
  logic cfg_we;
  logic cfg_index;
  logic [8:0] cfg_data;

  partition_table_checker_top #(.TABLE_ENTRIES(NENTRIES)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // geometry and table state of the local model
  logic [8:0]  geo_heads;
  logic [5:0]  geo_spt;
  logic [2:0]  act_cnt;
  logic [31:0] prev_end;
  logic [7:0]  max_hd;
  logic [5:0]  max_sc;
  logic        seen_nonempty;
  logic        seen_error;
  int          entry_idx;

  ptc_in_t  entry_q[$];
  ptc_out_t verdict_q[$];
  int  mismatches;
  bit  idle_off;
  bit  hold_req;
  int  idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [23:0] lba_chs(input logic [31:0] lba);
    logic [31:0] nh, ns, per_cyl, cyl;
    logic [7:0] hd, sc, cy;
    nh = (geo_heads == 0) ? 32'd1 : 32'(geo_heads);
    ns = (geo_spt == 0) ? 32'd1 : 32'(geo_spt);
    per_cyl = nh * ns;
    cyl = lba / per_cyl;
    sc = 8'((lba % ns) + 32'd1 + ((cyl >> 2) & 32'(CYL_HIGH_BITS)));
    cy = cyl[7:0];
    hd = 8'((lba % per_cyl) / ns);
    return {hd, sc, cy};
  endfunction

  function automatic void clear_table_state();
    act_cnt = 0;
    prev_end = 0;
    max_hd = 0;
    max_sc = 0;
    seen_nonempty = 0;
    seen_error = 0;
    entry_idx = 0;
  endfunction

  function automatic ptc_out_t check_entry(input ptc_in_t e);
    ptc_out_t r;
    logic [23:0] chs;
    logic [31:0] end_lba;
    logic [8:0] sug;
    r = '0;
    if (e.boot_flag == ACTIVE_MARK && act_cnt < ACTIVE_MAX) act_cnt++;
    chs = lba_chs(e.base_sector);
    r.base_mismatch = chs != {e.first_head, e.start_sector_field, e.start_cylinder_low};
    end_lba = e.base_sector + e.sector_count - 32'd1;
    if (e.base_sector == 0 && e.sector_count == 0) chs = '0;
    else chs = lba_chs(end_lba);
    r.size_mismatch = chs != {e.end_head, e.end_sector_field, e.end_cylinder_low};
    if (e.sector_count != 0) begin
      seen_nonempty = 1;
      r.overlap = e.base_sector <= prev_end;
      prev_end = end_lba;
      r.end_overflow = end_lba < e.base_sector;
      if (max_hd < e.first_head) max_hd = e.first_head;
      if (max_hd < e.end_head) max_hd = e.end_head;
      if (max_sc < e.start_sector_field[5:0]) max_sc = e.start_sector_field[5:0];
      if (max_sc < e.end_sector_field[5:0]) max_sc = e.end_sector_field[5:0];
    end
    if (r.base_mismatch || r.size_mismatch || r.overlap || r.end_overflow)
      seen_error = 1;
    entry_idx++;
    r.table_done = e.last_entry || entry_idx >= NENTRIES;
    if (r.table_done) begin
      sug = 9'(max_hd) + 9'd1;
      r.table_empty = !seen_nonempty;
      r.geometry_mismatch = seen_nonempty && (sug != geo_heads || max_sc != geo_spt);
      r.suggested_heads = sug;
      r.suggested_sectors = max_sc;
      r.too_many_active = act_cnt > 1;
      r.table_ok = !(seen_error || act_cnt > 1);
      clear_table_state();
    end
    return r;
  endfunction

  // builds an entry, mostly with consistent CHS fields for the current geometry
  function automatic ptc_in_t make_entry(input logic [31:0] base, input logic [31:0] cnt,
                                         input logic last, input bit good);
    ptc_in_t e;
    logic [23:0] chs;
    e.boot_flag = ($urandom_range(0, 3) == 0) ? ACTIVE_MARK : 8'($urandom_range(0, 1) ? 0 : $urandom);
    e.base_sector = base;
    e.sector_count = cnt;
    e.last_entry = last;
    if (good) begin
      chs = lba_chs(base);
      {e.first_head, e.start_sector_field, e.start_cylinder_low} = chs;
      chs = (base == 0 && cnt == 0) ? 24'd0 : lba_chs(base + cnt - 32'd1);
      {e.end_head, e.end_sector_field, e.end_cylinder_low} = chs;
      if ($urandom_range(0, 15) == 0) e.end_head ^= 8'(1 << $urandom_range(0, 7));
    end else begin
      {e.first_head, e.start_sector_field, e.start_cylinder_low} = 24'($urandom);
      {e.end_head, e.end_sector_field, e.end_cylinder_low} = 24'($urandom);
    end
    return e;
  endfunction

  // input side
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      in_data <= '0;
      in_gap <= 0;
    end else if (!in_push || !in_full) begin
      if (in_push) void'(entry_q.pop_front());
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_push <= 1'b0;
      end else if (entry_q.size() > 0) begin
        if (!idle_off && $urandom_range(0, 7) == 0) begin
          in_gap <= $urandom_range(0, 8);
          in_push <= 1'b0;
        end else begin
          in_push <= 1'b1;
          in_data <= entry_q[0];
          verdict_q.push_back(check_entry(entry_q[0]));
        end
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // output side
  int out_gap;
  int hold_cnt;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      out_gap <= 0;
      hold_cnt <= 0;
      mismatches <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (verdict_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected transfer %h", out_data);
        end else begin
          if (out_data !== verdict_q[0]) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch exp %h got %h", verdict_q[0], out_data);
          end
          void'(verdict_q.pop_front());
        end
      end
      if (hold_req && hold_cnt == 0) begin
        hold_cnt <= 400;
        out_pop <= 1'b0;
      end else if (hold_cnt > 1) begin
        hold_cnt <= hold_cnt - 1;
        out_pop <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_pop <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 8);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("tb_partition_table_checker_top NOT OK");
      $finish;
    end
  end

  task automatic set_reg(input logic idx, input logic [8:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_HEADS) geo_heads = val;
    else geo_spt = val[5:0];
  endtask

  task automatic drain();
    wait (entry_q.size() == 0 && verdict_q.size() == 0);
    repeat (150) @(posedge clk);
  endtask

  task automatic random_tables(input int n);
    logic [31:0] base, cnt;
    int k;
    k = 0;
    while (k < n) begin
      base = $urandom_range(1, 5000);
      for (int j = 0; j < NENTRIES && k < n; j++, k++) begin
        case ($urandom_range(0, 9))
          0: cnt = 0;
          1: cnt = $urandom;
          2: cnt = 32'hffffffff;
          default: cnt = $urandom_range(1, 20000);
        endcase
        if ($urandom_range(0, 19) == 0) base = $urandom;
        entry_q.push_back(make_entry(base, cnt, $urandom_range(0, 5) == 0,
                                     $urandom_range(0, 7) != 0));
        base = base + cnt + $urandom_range(0, 3);
      end
    end
  endtask

  initial begin
    idle_off = 0;
    hold_req = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_HEADS;
    cfg_data = '0;
    geo_heads = 9'd4;
    geo_spt = 6'd17;
    clear_table_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: defaults, extremes, empty tables, overlap at zero, wrap
    entry_q.push_back(make_entry(0, 0, 0, 1));
    entry_q.push_back(make_entry(0, 10, 0, 1));
    entry_q.push_back(make_entry(32'hffffffff, 32'hffffffff, 0, 1));
    entry_q.push_back(make_entry(32'hfffffff0, 32'h20, 1, 1));
    for (int i = 0; i < 4; i++) entry_q.push_back(make_entry(0, 0, 0, 0));
    begin
      ptc_in_t e;
      e = '1;
      entry_q.push_back(e);
      e = '0;
      e.boot_flag = ACTIVE_MARK;
      e.sector_count = 5;
      e.base_sector = 100;
      for (int i = 0; i < 9; i++) begin
        e.last_entry = (i % 3 == 2);
        entry_q.push_back(e);
      end
    end
    entry_q.push_back(make_entry(63, 100, 1, 1));
    drain();

    set_reg(CFG_HEADS, 9'd256);
    set_reg(CFG_SECTORS, 6'd63);
    random_tables(120);
    drain();
    set_reg(CFG_HEADS, 9'd1);
    set_reg(CFG_SECTORS, 6'd1);
    random_tables(100);
    drain();
    set_reg(CFG_HEADS, 9'd0);
    set_reg(CFG_SECTORS, 6'd0);
    random_tables(40);
    drain();
    set_reg(CFG_HEADS, 9'd511);
    set_reg(CFG_SECTORS, 6'd17);
    random_tables(40);
    drain();
    set_reg(CFG_HEADS, 9'd16);
    set_reg(CFG_SECTORS, 6'd63);
    hold_req <= 1'b1;
    random_tables(150);
    @(posedge clk);
    hold_req <= 1'b0;
    random_tables(100);
    drain();
    set_reg(CFG_HEADS, 9'($urandom_range(1, 256)));
    set_reg(CFG_SECTORS, 6'($urandom_range(1, 63)));
    random_tables(60);
    idle_off = 1;
    random_tables(60);
    wait (entry_q.size() == 0 && verdict_q.size() == 0);
    repeat (150) @(posedge clk);
    if (mismatches == 0) $display("tb_partition_table_checker_top OK");
    else $display("tb_partition_table_checker_top NOT OK");
    $finish;
  end
endmodule
